@@ hdl/spq_pkg.sv @@
// Shared types and codes for the sorted priority queue
package spq_pkg;

  localparam int ValueW  = 32;
  localparam int OccW    = 4;
  localparam int StatusW = 2;

  typedef enum logic [0:0] {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } spq_kind_t;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK         = 2'd0,
    STATUS_FULL_DROP  = 2'd1,
    STATUS_EMPTY_REM  = 2'd2
  } spq_status_t;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_HOLD = 1'b1
  } spq_state_t;

  typedef struct packed {
    logic load;
  } spq_cmd_t;

endpackage

@@ hdl/sorted_priority_queue_core.sv @@
// Sorted priority queue: insert below equal values, remove the largest.
// A result is registered and shown in the cycle after its item is accepted.
// Throughput: one item per cycle while results are taken; the whole sorted
// store compares and shifts at once.
// Reset clears the count and the handshake state; stored values are not
// cleared and are never read before being written.
module sorted_priority_queue_core
  import spq_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_kind,
  input  logic signed [ValueW-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [ValueW-1:0] out_removed_value,
  output logic signed [ValueW-1:0] out_top_value,
  output logic [OccW-1:0]          out_occupancy,
  output logic                     out_is_empty,
  output logic                     out_is_full,
  output logic [StatusW-1:0]       out_status
);

  spq_cmd_t cmd;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_kind           (in_kind),
    .in_value          (in_value),
    .out_removed_value (out_removed_value),
    .out_top_value     (out_top_value),
    .out_occupancy     (out_occupancy),
    .out_is_empty      (out_is_empty),
    .out_is_full       (out_is_full),
    .out_status        (out_status)
  );

endmodule

@@ hdl/spq_ctrl.sv @@
// Handshake controller for the sorted priority queue
module spq_ctrl
  import spq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output spq_cmd_t cmd
);

  spq_state_t state_r;
  spq_state_t state_nxt;
  logic       take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    unique case (state_r)
      ST_IDLE: begin
        in_stall  = 1'b0;
        out_valid = 1'b0;
      end
      ST_HOLD: begin
        in_stall  = out_stall;
        out_valid = 1'b1;
      end
      default: begin
        in_stall  = 1'b1;
        out_valid = 1'b0;
      end
    endcase
    take     = in_valid && !in_stall;
    cmd.load = take;
  end

  always_comb begin
    unique case (state_r)
      ST_IDLE: state_nxt = take ? ST_HOLD : ST_IDLE;
      ST_HOLD: begin
        if (take) begin
          state_nxt = ST_HOLD;
        end else if (!out_stall) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_HOLD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

@@ hdl/spq_datapath.sv @@
// Sorted store cells, count and result registers of the priority queue
module spq_datapath
  import spq_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  spq_cmd_t                 cmd,
  input  logic                     in_kind,
  input  logic signed [ValueW-1:0] in_value,
  output logic signed [ValueW-1:0] out_removed_value,
  output logic signed [ValueW-1:0] out_top_value,
  output logic [OccW-1:0]          out_occupancy,
  output logic                     out_is_empty,
  output logic                     out_is_full,
  output logic [StatusW-1:0]       out_status
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  // held largest first: cell 0 is the maximum
  logic signed [ValueW-1:0] store_r   [DEPTH];
  logic signed [ValueW-1:0] store_nxt [DEPTH];
  logic [CW-1:0]            count_r;
  logic [CW-1:0]            count_nxt;
  logic [DEPTH-1:0]         keep;
  logic signed [ValueW-1:0] removed;
  spq_status_t              status;
  logic [31:0]              count_ext;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      keep[i] = (CW'(i) < count_r) && (store_r[i] >= in_value);
    end
  end

  always_comb begin
    count_nxt = count_r;
    removed   = '0;
    status    = STATUS_OK;
    for (int i = 0; i < DEPTH; i++) begin
      store_nxt[i] = store_r[i];
    end
    if (spq_kind_t'(in_kind) == KIND_INSERT) begin
      if (count_r == DepthC) begin
        status = STATUS_FULL_DROP;
      end else begin
        count_nxt = count_r + CW'(1);
        for (int i = 0; i < DEPTH; i++) begin
          if (keep[i]) begin
            store_nxt[i] = store_r[i];
          end else if (i == 0) begin
            store_nxt[i] = in_value;
          end else if (keep[(i == 0) ? 0 : i - 1]) begin
            store_nxt[i] = in_value;
          end else begin
            store_nxt[i] = store_r[(i == 0) ? 0 : i - 1];
          end
        end
      end
    end else begin
      if (count_r == '0) begin
        status = STATUS_EMPTY_REM;
      end else begin
        count_nxt = count_r - CW'(1);
        removed   = store_r[0];
        for (int i = 0; i < DEPTH - 1; i++) begin
          store_nxt[i] = store_r[i + 1];
        end
      end
    end
    count_ext = {{(32 - CW){1'b0}}, count_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.load) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < DEPTH; i++) begin
        store_r[i] <= store_nxt[i];
      end
      out_removed_value <= removed;
      out_top_value     <= (count_nxt != '0) ? store_nxt[0] : '0;
      out_occupancy     <= count_ext[OccW-1:0];
      out_is_empty      <= (count_nxt == '0);
      out_is_full       <= (count_nxt == DepthC);
      out_status        <= status;
    end
  end

endmodule
